// File: rtl/fpbb_pkg.sv
// ----------------------------------------------------------------------------
// Feature point bounding box package
// Field widths, configuration register indexes and the per-frame extreme
// tracking record shared by the block, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbb_pkg;

  // Input item fields, full resolution.
  localparam int PX_W = 10;
  localparam int PY_W = 9;

  // Grid coordinates after halving, and result fields.
  localparam int COL_W = 9;
  localparam int ROW_W = 8;

  // Consecutive empty frame counter.
  localparam int MISS_W = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_OUTER_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_X         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_Y         = 2'd2;

  // Running extremes of one frame. Each value carries its own valid bit.
  typedef struct packed {
    logic             any_point;
    logic             row_high_v;
    logic [ROW_W-1:0] row_high;
    logic             row_low_v;
    logic [ROW_W-1:0] row_low;
    logic             col_low_first_v;
    logic [COL_W-1:0] col_low_first;
    logic             col_low_second_v;
    logic [COL_W-1:0] col_low_second;
    logic             col_high_first_v;
    logic [COL_W-1:0] col_high_first;
    logic             col_high_second_v;
    logic [COL_W-1:0] col_high_second;
  } extremes_t;

endpackage

`default_nettype wire

// File: rtl/fpbb_if.sv
// ----------------------------------------------------------------------------
// Feature point bounding box channels
// Valid/ready channels for incoming feature points and outgoing boxes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpbb_point_if;
  import fpbb_pkg::*;

  logic            valid;
  logic            ready;
  logic [PX_W-1:0] point_x;
  logic [PY_W-1:0] point_y;
  logic            point_valid;
  logic            frame_last;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output frame_last, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_valid,
                  input frame_last, output ready);
endinterface

interface fpbb_box_if;
  import fpbb_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] box_top;
  logic [ROW_W-1:0] box_bottom;
  logic [COL_W-1:0] box_left;
  logic [COL_W-1:0] box_right;
  logic             draw_enable;
  logic             points_found;

  modport source (output valid, output box_top, output box_bottom, output box_left,
                  output box_right, output draw_enable, output points_found,
                  input ready);
  modport sink   (input valid, input box_top, input box_bottom, input box_left,
                  input box_right, input draw_enable, input points_found,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/feature_point_bounding_box_core.sv
// ----------------------------------------------------------------------------
// Feature point bounding box core
// Tracks the extremes of a frame's feature points and emits one margin-grown,
// clamped box per frame, with a draw enable from a count of empty frames.
// ----------------------------------------------------------------------------
// The block takes one point item per clock and keeps doing so while a box
// waits at the output. An item passes an input register and then a single
// compare-and-select step that updates the running extremes; the item that
// closes a frame also computes the box and loads the output register, so a
// box appears once its last item has left the input register. The only stall is
// a frame end that meets a full output register whose box is not yet taken.
// There is no clearing pass after reset; configuration writes take effect on
// the next frame end.
`default_nettype none

module feature_point_bounding_box_core #(
  parameter int GRID_W      = 320,
  parameter int GRID_H      = 240,
  parameter int EDGE_MARGIN = 10,
  parameter int MISS_LIMIT  = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fpbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpbb_pkg::CFG_DATA_W-1:0] cfg_data,
  fpbb_point_if.sink                     points,
  fpbb_box_if.source                     boxes
);
  import fpbb_pkg::*;

  localparam int M = EDGE_MARGIN;

  // Scan windows.
  localparam int TOP_LO   = M + 1;
  localparam int TOP_HI   = GRID_H - M;
  localparam int BOT_LO   = M;
  localparam int BOT_HI   = GRID_H - M - 1;
  localparam int LEFT_LO  = M;
  localparam int LEFT_HI  = GRID_W - M - 1;
  localparam int RIGHT_LO = M + 1;
  localparam int RIGHT_HI = GRID_W - M;

  // Values a side takes when nothing landed in its window.
  localparam int TOP_DEF   = (TOP_LO <= TOP_HI) ? TOP_LO : 0;
  localparam int BOT_DEF   = (BOT_LO <= BOT_HI) ? BOT_HI : 0;
  localparam int LEFT_DEF  = (LEFT_LO <= LEFT_HI) ? LEFT_HI : 0;
  localparam int RIGHT_DEF = (RIGHT_LO <= RIGHT_HI) ? RIGHT_LO : 0;

  // Signed width that holds every grid or fallback value plus two margins.
  localparam int GMAX = (GRID_W > GRID_H) ? ((GRID_W > 512) ? GRID_W : 512)
                                          : ((GRID_H > 512) ? GRID_H : 512);
  localparam int VW   = $clog2(GMAX + 2 * M + 1) + 1;

  localparam logic [MISS_W-1:0] MISS_MAX = MISS_W'(MISS_LIMIT);

  typedef logic signed [VW-1:0] val_t;

  // Configuration registers.
  logic             trim_outer_columns;
  logic [COL_W-1:0] fallback_x;
  logic [ROW_W-1:0] fallback_y;

  // Input register, coordinates already halved.
  logic             ir_valid;
  logic [COL_W-1:0] ir_col;
  logic [ROW_W-1:0] ir_row;
  logic             ir_point;
  logic             ir_last;

  extremes_t         ext;
  extremes_t         ext_next;
  logic [MISS_W-1:0] miss_count;
  logic [MISS_W-1:0] miss_count_next;

  // Output register.
  logic             ov;
  logic [ROW_W-1:0] o_top;
  logic [ROW_W-1:0] o_bottom;
  logic [COL_W-1:0] o_left;
  logic [COL_W-1:0] o_right;
  logic             o_draw;
  logic             o_found;

  logic out_free;
  logic ir_go;
  logic in_take;

  val_t pre_top, pre_bot, pre_left, pre_right;
  val_t top_sum, bot_dif, left_dif, right_sum;
  val_t top_fin, bot_fin, left_fin, right_fin;

  assign out_free      = !ov || boxes.ready;
  assign ir_go         = ir_valid && (!ir_last || out_free);
  assign points.ready  = !rst && (!ir_valid || ir_go);
  assign in_take       = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_outer_columns <= 1'b0;
      fallback_x         <= '0;
      fallback_y         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIM_OUTER_COLUMNS: trim_outer_columns <= cfg_data[0];
        CFG_FALLBACK_X:         fallback_x         <= cfg_data[COL_W-1:0];
        CFG_FALLBACK_Y:         fallback_y         <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_take) begin
      ir_valid <= 1'b1;
    end else if (ir_go) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_col   <= points.point_x[PX_W-1:1];
      ir_row   <= points.point_y[PY_W-1:1];
      ir_point <= points.point_valid;
      ir_last  <= points.frame_last;
    end
  end

  // Fold the current point into the running extremes.
  always_comb begin
    ext_next = ext;
    if (ir_point) begin
      ext_next.any_point = 1'b1;
      if (int'(ir_col) < GRID_W) begin
        if (int'(ir_row) >= TOP_LO && int'(ir_row) <= TOP_HI &&
            (!ext.row_high_v || ir_row > ext.row_high)) begin
          ext_next.row_high   = ir_row;
          ext_next.row_high_v = 1'b1;
        end
        if (int'(ir_row) >= BOT_LO && int'(ir_row) <= BOT_HI &&
            (!ext.row_low_v || ir_row < ext.row_low)) begin
          ext_next.row_low   = ir_row;
          ext_next.row_low_v = 1'b1;
        end
      end
      if (int'(ir_row) < GRID_H) begin
        if (int'(ir_col) >= LEFT_LO && int'(ir_col) <= LEFT_HI) begin
          if (!ext.col_low_first_v || ir_col < ext.col_low_first) begin
            // The old first column moves down to second place.
            ext_next.col_low_second   = ext.col_low_first;
            ext_next.col_low_second_v = ext.col_low_first_v;
            ext_next.col_low_first    = ir_col;
            ext_next.col_low_first_v  = 1'b1;
          end else if (ir_col != ext.col_low_first &&
                       (!ext.col_low_second_v || ir_col < ext.col_low_second)) begin
            ext_next.col_low_second   = ir_col;
            ext_next.col_low_second_v = 1'b1;
          end
        end
        if (int'(ir_col) >= RIGHT_LO && int'(ir_col) <= RIGHT_HI) begin
          if (!ext.col_high_first_v || ir_col > ext.col_high_first) begin
            ext_next.col_high_second   = ext.col_high_first;
            ext_next.col_high_second_v = ext.col_high_first_v;
            ext_next.col_high_first    = ir_col;
            ext_next.col_high_first_v  = 1'b1;
          end else if (ir_col != ext.col_high_first &&
                       (!ext.col_high_second_v || ir_col > ext.col_high_second)) begin
            ext_next.col_high_second   = ir_col;
            ext_next.col_high_second_v = 1'b1;
          end
        end
      end
    end
  end

  // Raw box sides, before margin and clamp.
  always_comb begin
    if (ext_next.any_point) begin
      pre_top = ext_next.row_high_v ? val_t'(ext_next.row_high) : val_t'(TOP_DEF);
      pre_bot = ext_next.row_low_v ? val_t'(ext_next.row_low) : val_t'(BOT_DEF);
      if (trim_outer_columns) begin
        pre_left  = ext_next.col_low_second_v ? val_t'(ext_next.col_low_second)
                                              : val_t'(LEFT_DEF);
        pre_right = ext_next.col_high_second_v ? val_t'(ext_next.col_high_second)
                                               : val_t'(RIGHT_DEF);
      end else begin
        pre_left  = ext_next.col_low_first_v ? val_t'(ext_next.col_low_first)
                                             : val_t'(LEFT_DEF);
        pre_right = ext_next.col_high_first_v ? val_t'(ext_next.col_high_first)
                                              : val_t'(RIGHT_DEF);
      end
    end else begin
      pre_top   = val_t'(fallback_y) + val_t'(M);
      pre_bot   = val_t'(fallback_y) - val_t'(M);
      pre_left  = val_t'(fallback_x) - val_t'(M);
      pre_right = val_t'(fallback_x) + val_t'(M);
    end
  end

  always_comb begin
    top_sum   = pre_top + val_t'(M);
    bot_dif   = pre_bot - val_t'(M);
    left_dif  = pre_left - val_t'(M);
    right_sum = pre_right + val_t'(M);
    top_fin   = (top_sum > val_t'(GRID_H - 1)) ? val_t'(GRID_H - 1) : top_sum;
    bot_fin   = (bot_dif < val_t'(0)) ? val_t'(0) : bot_dif;
    left_fin  = (left_dif < val_t'(0)) ? val_t'(0) : left_dif;
    right_fin = (right_sum > val_t'(GRID_W - 1)) ? val_t'(GRID_W - 1) : right_sum;
  end

  always_comb begin
    if (ext_next.any_point) begin
      miss_count_next = '0;
    end else if (miss_count < MISS_MAX) begin
      miss_count_next = miss_count + MISS_W'(1);
    end else begin
      miss_count_next = miss_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext        <= '0;
      miss_count <= '0;
    end else if (ir_go) begin
      if (ir_last) begin
        ext        <= '0;
        miss_count <= miss_count_next;
      end else begin
        ext <= ext_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ir_go && ir_last) begin
      ov <= 1'b1;
    end else if (boxes.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ir_go && ir_last) begin
      o_top    <= top_fin[ROW_W-1:0];
      o_bottom <= bot_fin[ROW_W-1:0];
      o_left   <= left_fin[COL_W-1:0];
      o_right  <= right_fin[COL_W-1:0];
      o_draw   <= (miss_count_next < MISS_MAX);
      o_found  <= ext_next.any_point;
    end
  end

  assign boxes.valid        = ov;
  assign boxes.box_top      = o_top;
  assign boxes.box_bottom   = o_bottom;
  assign boxes.box_left     = o_left;
  assign boxes.box_right    = o_right;
  assign boxes.draw_enable  = o_draw;
  assign boxes.points_found = o_found;

endmodule

`default_nettype wire

// File: rtl/fpbb_checker.sv
// ----------------------------------------------------------------------------
// Feature point bounding box checker
// Port-level properties of the bounding box core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fpbb_pkg::ROW_W-1:0] box_top,
  input logic [fpbb_pkg::ROW_W-1:0] box_bottom,
  input logic [fpbb_pkg::COL_W-1:0] box_left,
  input logic [fpbb_pkg::COL_W-1:0] box_right,
  input logic                       draw_enable,
  input logic                       points_found
);
  import fpbb_pkg::*;

  // A box that waits is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("box withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(box_top) && $stable(box_bottom) &&
      $stable(box_left) && $stable(box_right) && $stable(draw_enable) &&
      $stable(points_found))
    else $error("box changed while stalled");

  // A fresh box follows an accepted frame end.
  a_box_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("box without a frame end");

  // A frame with points clears the miss count, so drawing is enabled.
  a_found_draws: assert property (@(posedge clk) disable iff (rst)
    out_valid && points_found |-> draw_enable)
    else $error("draw disabled on a frame with points");

endmodule

bind feature_point_bounding_box_core fpbb_checker u_fpbb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (points.valid),
  .in_ready     (points.ready),
  .in_last      (points.frame_last),
  .out_valid    (boxes.valid),
  .out_ready    (boxes.ready),
  .box_top      (boxes.box_top),
  .box_bottom   (boxes.box_bottom),
  .box_left     (boxes.box_left),
  .box_right    (boxes.box_right),
  .draw_enable  (boxes.draw_enable),
  .points_found (boxes.points_found)
);

`default_nettype wire

// File: dv/fpbb_tb_pkg.sv
// ----------------------------------------------------------------------------
// Feature point bounding box checker
// Item types and a scoreboard that rebuilds the expected box of every frame
// from the accepted point items and matches it against the boxes the block
// delivers.
// ----------------------------------------------------------------------------
package fpbb_tb_pkg;
  import fpbb_pkg::*;

  localparam int GRID_W     = 320;
  localparam int GRID_H     = 240;
  localparam int MARGIN     = 10;
  localparam int MISS_LIMIT = 4;

  typedef struct packed {
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
    logic            has_point;
    logic            is_last;
  } point_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic             draw_enable;
    logic             points_found;
  } box_t;

  class frame_box_scoreboard;
    logic             trim_mode;
    logic [COL_W-1:0] centre_x;
    logic [ROW_W-1:0] centre_y;
    extremes_t        ext;
    logic [MISS_W-1:0] empty_frames;
    box_t             pending_boxes[$];
    int unsigned      mismatches;

    function new();
      trim_mode    = 1'b0;
      centre_x     = '0;
      centre_y     = '0;
      ext          = '0;
      empty_frames = '0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_TRIM_OUTER_COLUMNS: trim_mode = data[0];
        CFG_FALLBACK_X:         centre_x  = data[COL_W-1:0];
        CFG_FALLBACK_Y:         centre_y  = data[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_boxes.size();
    endfunction

    // Column extremes keep the first and second distinct column from each side.
    function void add_point(int col, int row);
      ext.any_point = 1'b1;
      if (col < GRID_W) begin
        if (row >= MARGIN + 1 && row <= GRID_H - MARGIN &&
            (!ext.row_high_v || row > int'(ext.row_high))) begin
          ext.row_high   = ROW_W'(row);
          ext.row_high_v = 1'b1;
        end
        if (row >= MARGIN && row <= GRID_H - MARGIN - 1 &&
            (!ext.row_low_v || row < int'(ext.row_low))) begin
          ext.row_low   = ROW_W'(row);
          ext.row_low_v = 1'b1;
        end
      end
      if (row < GRID_H) begin
        if (col >= MARGIN && col <= GRID_W - MARGIN - 1) begin
          if (!ext.col_low_first_v || col < int'(ext.col_low_first)) begin
            if (ext.col_low_first_v) begin
              ext.col_low_second   = ext.col_low_first;
              ext.col_low_second_v = 1'b1;
            end
            ext.col_low_first   = COL_W'(col);
            ext.col_low_first_v = 1'b1;
          end else if (col != int'(ext.col_low_first) &&
                       (!ext.col_low_second_v || col < int'(ext.col_low_second))) begin
            ext.col_low_second   = COL_W'(col);
            ext.col_low_second_v = 1'b1;
          end
        end
        if (col >= MARGIN + 1 && col <= GRID_W - MARGIN) begin
          if (!ext.col_high_first_v || col > int'(ext.col_high_first)) begin
            if (ext.col_high_first_v) begin
              ext.col_high_second   = ext.col_high_first;
              ext.col_high_second_v = 1'b1;
            end
            ext.col_high_first   = COL_W'(col);
            ext.col_high_first_v = 1'b1;
          end else if (col != int'(ext.col_high_first) &&
                       (!ext.col_high_second_v || col > int'(ext.col_high_second))) begin
            ext.col_high_second   = COL_W'(col);
            ext.col_high_second_v = 1'b1;
          end
        end
      end
    endfunction

    function box_t close_frame();
      int   top;
      int   bottom;
      int   left;
      int   right;
      box_t b;
      if (ext.any_point) begin
        empty_frames = '0;
        top    = ext.row_high_v ? int'(ext.row_high) : MARGIN + 1;
        bottom = ext.row_low_v ? int'(ext.row_low) : GRID_H - MARGIN - 1;
        if (trim_mode) begin
          left  = ext.col_low_second_v ? int'(ext.col_low_second) : GRID_W - MARGIN - 1;
          right = ext.col_high_second_v ? int'(ext.col_high_second) : MARGIN + 1;
        end else begin
          left  = ext.col_low_first_v ? int'(ext.col_low_first) : GRID_W - MARGIN - 1;
          right = ext.col_high_first_v ? int'(ext.col_high_first) : MARGIN + 1;
        end
      end else begin
        if (empty_frames < MISS_LIMIT) empty_frames = empty_frames + 1'b1;
        top    = int'(centre_y) + MARGIN;
        bottom = int'(centre_y) - MARGIN;
        left   = int'(centre_x) - MARGIN;
        right  = int'(centre_x) + MARGIN;
      end
      top    = (top + MARGIN > GRID_H - 1) ? GRID_H - 1 : top + MARGIN;
      bottom = (bottom - MARGIN < 0) ? 0 : bottom - MARGIN;
      left   = (left - MARGIN < 0) ? 0 : left - MARGIN;
      right  = (right + MARGIN > GRID_W - 1) ? GRID_W - 1 : right + MARGIN;
      b.top          = ROW_W'(top);
      b.bottom       = ROW_W'(bottom);
      b.left         = COL_W'(left);
      b.right        = COL_W'(right);
      b.draw_enable  = (empty_frames < MISS_LIMIT);
      b.points_found = ext.any_point;
      ext = '0;
      return b;
    endfunction

    function void note_point(point_item_t item);
      if (item.has_point) add_point(int'(item.x >> 1), int'(item.y >> 1));
      if (item.is_last) pending_boxes.insert(pending_boxes.size(), close_frame());
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_box(box_t got);
      box_t want;
      if (pending_boxes.size() == 0) begin
        report_mismatch("box delivered with no frame closed");
      end else begin
        want = pending_boxes.pop_front();
        compare_field("box_top", got.top, want.top);
        compare_field("box_bottom", got.bottom, want.bottom);
        compare_field("box_left", got.left, want.left);
        compare_field("box_right", got.right, want.right);
        compare_field("draw_enable", got.draw_enable, want.draw_enable);
        compare_field("points_found", got.points_found, want.points_found);
      end
    endtask
  endclass

endpackage

// File: dv/feature_point_bounding_box_core_tb.sv
// ----------------------------------------------------------------------------
// Feature point bounding box core testbench
// Streams directed and random frames of feature points through the block under
// changing register settings and idle patterns, and checks every box against
// a scoreboard that predicts it from the accepted items.
// ----------------------------------------------------------------------------
module feature_point_bounding_box_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpbb_pkg::*;
  import fpbb_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 104;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpbb_point_if point_ch ();
  fpbb_box_if   box_ch ();

  frame_box_scoreboard sb = new();

  int sender_idle_pct = 0;
  int ready_stall_pct = 0;
  int hold_cycles     = 0;
  int quiet_cycles    = 0;
  int prev_x          = 0;

  feature_point_bounding_box_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (point_ch),
    .boxes     (box_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && point_ch.valid && point_ch.ready) begin
      sb.note_point('{point_ch.point_x, point_ch.point_y, point_ch.point_valid,
                      point_ch.frame_last});
    end
    if (!rst && box_ch.valid && box_ch.ready) begin
      sb.check_box('{box_ch.box_top, box_ch.box_bottom, box_ch.box_left, box_ch.box_right,
                     box_ch.draw_enable, box_ch.points_found});
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (point_ch.valid && point_ch.ready) || (box_ch.valid && box_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Box receiver. A requested hold-off keeps ready low for a long stretch so
  // that the output register stays full and the input backs up.
  initial begin
    box_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        box_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        box_ch.ready = ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  task automatic send_item(input int x, input int y, input bit has_point, input bit is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      point_ch.valid = 1'b0;
      @(negedge clk);
    end
    point_ch.valid       = 1'b1;
    point_ch.point_x     = PX_W'(x);
    point_ch.point_y     = PY_W'(y);
    point_ch.point_valid = has_point;
    point_ch.frame_last  = is_last;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_register(index, CFG_DATA_W'(value));
  endtask

  // Every phase ends on a frame end, so an empty queue means that the input
  // and output registers of the block hold no work.
  task automatic settle();
    point_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input int trim, input int fx, input int fy);
    write_reg(CFG_TRIM_OUTER_COLUMNS, trim);
    write_reg(CFG_FALLBACK_X, fx);
    write_reg(CFG_FALLBACK_Y, fy);
  endtask

  // Columns near the window edges and repeated columns matter most for the
  // first and second extremes; off-grid values are kept rare.
  function automatic int pick_x();
    int x;
    case ($urandom_range(9))
      5:       x = $urandom_range(14, 28);
      6:       x = $urandom_range(612, 627);
      7:       x = prev_x;
      8:       x = $urandom_range(1) ? $urandom_range(0, 31) : $urandom_range(608, 639);
      9:       x = ($urandom_range(9) == 0) ? $urandom_range(640, 1023) : $urandom_range(639);
      default: x = $urandom_range(639);
    endcase
    prev_x = x;
    return x;
  endfunction

  function automatic int pick_y();
    int y;
    case ($urandom_range(9))
      5:       y = $urandom_range(16, 26);
      6:       y = $urandom_range(454, 466);
      7:       y = $urandom_range(1) ? $urandom_range(0, 15) : $urandom_range(464, 479);
      8:       y = ($urandom_range(9) == 0) ? $urandom_range(480, 511) : $urandom_range(479);
      default: y = $urandom_range(479);
    endcase
    return y;
  endfunction

  task automatic run_directed();
    // Empty frames drive the miss count to its limit and hold it there.
    repeat (5) send_item(0, 0, 1'b0, 1'b1);
    // A lone point outside every window, carried on the frame end.
    send_item(0, 0, 1'b1, 1'b1);
    // Points right on the window limits.
    send_item(20, 22, 1'b1, 1'b0);
    send_item(618, 460, 1'b1, 1'b0);
    send_item(22, 20, 1'b1, 1'b0);
    send_item(620, 458, 1'b1, 1'b0);
    send_item(0, 0, 1'b0, 1'b1);
    // Off-grid points, an ignored item and the largest on-grid point.
    send_item(1023, 100, 1'b1, 1'b0);
    send_item(100, 511, 1'b1, 1'b0);
    send_item(1023, 511, 1'b0, 1'b0);
    send_item(639, 479, 1'b1, 1'b1);
    send_item(700, 50, 1'b1, 1'b1);
    settle();
    apply_setting(1, 319, 239);
    // Trim mode with a single occupied column.
    send_item(200, 200, 1'b1, 1'b0);
    send_item(201, 100, 1'b1, 1'b1);
    // Trim mode with a repeated outer column on each side.
    send_item(100, 300, 1'b1, 1'b0);
    send_item(101, 10, 1'b1, 1'b0);
    send_item(300, 40, 1'b1, 1'b0);
    send_item(500, 400, 1'b1, 1'b0);
    send_item(501, 400, 1'b1, 1'b1);
    send_item(0, 0, 1'b0, 1'b1);
  endtask

  task automatic random_frames(input int target);
    int sent;
    int kind;
    int n;
    bit end_on_point;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(19);
      if (kind == 0) begin
        send_item(pick_x(), pick_y(), 1'b0, 1'b0);
      end else if (kind <= 2) begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(pick_x(), pick_y(), 1'b0, 1'b1);
        sent += n;
      end else begin
        n = (kind == 3) ? $urandom_range(13, 40) : $urandom_range(1, 10);
        end_on_point = $urandom_range(1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(15) == 0) send_item(pick_x(), pick_y(), 1'b0, 1'b0);
          send_item(pick_x(), pick_y(), 1'b1, end_on_point && i == n - 1);
        end
        if (!end_on_point) send_item(pick_x(), pick_y(), 1'b0, 1'b1);
        sent += end_on_point ? n : n + 1;
      end
    end
    // Close the phase on a frame end so that nothing is left in flight.
    send_item(pick_x(), pick_y(), 1'b0, 1'b1);
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    point_ch.valid       = 1'b0;
    point_ch.point_x     = '0;
    point_ch.point_y     = '0;
    point_ch.point_valid = 1'b0;
    point_ch.frame_last  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       apply_setting(0, 0, 0);
        1:       apply_setting(1, 319, 239);
        2:       apply_setting(0, 319, 0);
        3:       apply_setting(1, 0, 239);
        default: apply_setting($urandom_range(1), $urandom_range(319), $urandom_range(239));
      endcase
      case (phase % 4)
        0: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; ready_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  ready_stall_pct = 83; end
        default: begin sender_idle_pct = 35; ready_stall_pct = 35; end
      endcase
      if (phase == 4) hold_cycles = HOLD_CYCLES;
      random_frames(PHASE_ITEMS);
    end

    point_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fpbb_pkg.sv
rtl/fpbb_if.sv
rtl/feature_point_bounding_box_core.sv
rtl/fpbb_checker.sv
dv/fpbb_tb_pkg.sv
dv/feature_point_bounding_box_core_tb.sv
